// ----- rtl/smp_pkg.sv -----
`timescale 1ns / 1ps

package smp_pkg;

	// Defaults for the top-level parameters.
	localparam int DEF_MAX_ROWS   = 64;
	localparam int DEF_VALUE_BITS = 64;

	// Fixed field widths on the stream ports.
	localparam int FIELD_BITS  = 64;
	localparam int MASK_BITS   = 8;
	localparam int CNT_W       = 7;
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 72;

	// A kept last element is not sent once this many nulls are queued for the column.
	localparam int RESULT_LIMIT = 64;

	// Output queue between the control logic and the master side.
	localparam int OBUF_DEPTH = 4;
	localparam int OBUF_PTR_W = 2;
	localparam int OBUF_LVL_W = 3;

	// One result beat as it travels to the output queue.
	typedef struct packed {
		logic [FIELD_BITS-1:0] value;
		logic                  kept;
		logic                  final_res;
		logic [CNT_W-1:0]      good_count;
		logic                  overflow;
	} beat_t;

endpackage

// ----- rtl/smp_store.sv -----
`timescale 1ns / 1ps

module smp_store #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port; the contents need no reset.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/smp_obuf.sv -----
`timescale 1ns / 1ps

module smp_obuf
	import smp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  beat_t                 push_beat,
	input  logic                  out_ready,
	output logic                  out_valid,
	output beat_t                 out_beat,
	output logic [OBUF_LVL_W-1:0] level
);

	beat_t                 fifo_q [OBUF_DEPTH];
	logic [OBUF_PTR_W-1:0] wr_ptr_q;
	logic [OBUF_PTR_W-1:0] rd_ptr_q;
	logic [OBUF_LVL_W-1:0] level_q;
	logic                  pop;

	assign out_valid = (level_q != '0);
	assign out_beat  = fifo_q[rd_ptr_q];
	assign level     = level_q;
	assign pop       = out_valid && out_ready;

	// Beat storage; the writer never pushes into a full queue.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_beat;
		end
	end

	// Pointers wrap on their own as the depth is a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + OBUF_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OBUF_PTR_W'(1);
			end
			level_q <= level_q + OBUF_LVL_W'(push) - OBUF_LVL_W'(pop);
		end
	end

endmodule

// ----- rtl/stable_mask_partition.sv -----
`timescale 1ns / 1ps

// Stable partition of one column by a mask byte.
// Slave side: one element a beat; tdata holds the value and the mask byte, tlast marks
// the last element of the column. A mask byte of exactly 1 keeps the value, which
// is pushed into the output queue in the cycle it is taken. Any other mask byte queues
// the value in an on-chip store of MAX_ROWS entries.
// Master side: tdata holds value, kept count and overflow flag, tuser says whether the
// beat is a kept value, tlast marks the last beat of the column.
// Throughput: one element a cycle while the master side takes beats. After the last
// element the queued values drain at one beat a cycle through the single registered
// read port of the store; no element is taken during the drain.
// A four-beat output queue decouples the two sides, so a stall on the master side
// holds the drain and, once the queue is full, the slave side.
// Reset clears the counters, the flags and the output queue; the store needs no
// clearing, as only entries written earlier in the same column are read.
module stable_mask_partition
	import smp_pkg::*;
#(
	parameter int MAX_ROWS   = DEF_MAX_ROWS,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // value[63:0], mask[71:64]
	input  logic                   s_tlast,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // out_value[63:0], good_count[70:64], overflow[71]
	output logic                   m_tuser,  // kept
	output logic                   m_tlast
);

	localparam int AW = $clog2(MAX_ROWS);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ROWS);

	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] null_total_q;
	logic [CNT_W-1:0] kept_total_q;
	logic             overflow_q;
	logic [CNT_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] drain_len_q;
	logic [CNT_W-1:0] fin_good_q;
	logic             fin_ovf_q;
	logic             rd_s1;
	logic             last_s1;

	logic [FIELD_BITS-1:0]       in_value;
	logic signed [MASK_BITS-1:0] in_mask;
	logic                        in_keep;
	logic [VALUE_BITS-1:0]       value_trim;
	logic                        room;
	logic                        accept;
	logic [CNT_W:0]              row_sum;
	logic                        beyond;
	logic                        ovf_next;
	logic                        keep_emit;
	logic [CNT_W-1:0]            kept_next;
	logic                        null_store;
	logic [CNT_W-1:0]            null_next;
	logic                        acc_final;
	logic                        acc_push;
	beat_t                       acc_beat;
	logic                        rd_issue;
	logic                        rd_last;
	logic [VALUE_BITS-1:0]       rd_data;
	beat_t                       drain_beat;
	logic                        push;
	beat_t                       push_beat;
	logic                        obuf_valid;
	beat_t                       obuf_beat;
	logic [OBUF_LVL_W-1:0]       obuf_level;

	// Unpack the slave beat.
	assign in_value   = s_tdata[FIELD_BITS-1:0];
	assign in_mask    = s_tdata[IN_TDATA_W-1:FIELD_BITS];
	assign in_keep    = (in_mask == 8'sd1);
	assign value_trim = in_value[VALUE_BITS-1:0];

	// Space for a new beat, counting the store read whose data is pushed in this cycle.
	assign room     = (obuf_level + OBUF_LVL_W'(rd_s1)) < OBUF_LVL_W'(OBUF_DEPTH);
	assign s_tready = (state_q == ST_IDLE) && !rd_s1 && room;
	assign accept   = s_tvalid && s_tready;

	// Row limit, counters and overflow for the element on the slave side.
	assign row_sum    = {1'b0, kept_total_q} + {1'b0, null_total_q};
	assign beyond     = row_sum >= (CNT_W + 1)'(MAX_ROWS);
	assign ovf_next   = overflow_q | beyond;
	assign keep_emit  = in_keep && !(s_tlast && (null_total_q >= CNT_W'(RESULT_LIMIT)));
	assign kept_next  = kept_total_q + CNT_W'(keep_emit && (kept_total_q < MAX_CNT));
	assign null_store = !in_keep && !beyond;
	assign null_next  = null_total_q + CNT_W'(null_store);

	// Beat pushed in the cycle an element is taken: a kept value, a final beat when no nulls are queued, or both.
	assign acc_final = s_tlast && (null_next == '0);
	assign acc_push  = accept && (keep_emit || acc_final);
	always_comb begin
		acc_beat            = '0;
		acc_beat.value      = keep_emit ? FIELD_BITS'(value_trim) : '0;
		acc_beat.kept       = keep_emit;
		acc_beat.final_res  = acc_final;
		acc_beat.good_count = acc_final ? kept_next : '0;
		acc_beat.overflow   = acc_final & ovf_next;
	end

	// Drain reads, one entry a cycle while the output queue has room.
	assign rd_issue = (state_q == ST_DRAIN) && room;
	assign rd_last  = (rd_ptr_q + CNT_W'(1)) == drain_len_q;

	smp_store #(
		.DEPTH (MAX_ROWS),
		.WIDTH (VALUE_BITS)
	) u_store (
		.clk     (clk),
		.wr_en   (accept && null_store),
		.wr_addr (null_total_q[AW-1:0]),
		.wr_data (value_trim),
		.rd_en   (rd_issue),
		.rd_addr (rd_ptr_q[AW-1:0]),
		.rd_data (rd_data)
	);

	// Queued value returning from the store.
	always_comb begin
		drain_beat            = '0;
		drain_beat.value      = FIELD_BITS'(rd_data);
		drain_beat.kept       = 1'b0;
		drain_beat.final_res  = last_s1;
		drain_beat.good_count = last_s1 ? fin_good_q : '0;
		drain_beat.overflow   = last_s1 & fin_ovf_q;
	end

	// The two sources never push in the same cycle.
	assign push      = acc_push || rd_s1;
	assign push_beat = rd_s1 ? drain_beat : acc_beat;

	smp_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_beat (push_beat),
		.out_ready (m_tready),
		.out_valid (obuf_valid),
		.out_beat  (obuf_beat),
		.level     (obuf_level)
	);

	assign m_tvalid = obuf_valid;
	assign m_tdata  = {obuf_beat.overflow, obuf_beat.good_count, obuf_beat.value};
	assign m_tuser  = obuf_beat.kept;
	assign m_tlast  = obuf_beat.final_res;

	// Column state, drain sequencer and read pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			null_total_q <= '0;
			kept_total_q <= '0;
			overflow_q   <= 1'b0;
			rd_ptr_q     <= '0;
			drain_len_q  <= '0;
			fin_good_q   <= '0;
			fin_ovf_q    <= 1'b0;
			rd_s1        <= 1'b0;
			last_s1      <= 1'b0;
		end else begin
			rd_s1   <= rd_issue;
			last_s1 <= rd_issue && rd_last;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_tlast) begin
							null_total_q <= '0;
							kept_total_q <= '0;
							overflow_q   <= 1'b0;
							fin_good_q   <= kept_next;
							fin_ovf_q    <= ovf_next;
							rd_ptr_q     <= '0;
							drain_len_q  <= null_next;
							if (null_next != '0) begin
								state_q <= ST_DRAIN;
							end
						end else begin
							null_total_q <= null_next;
							kept_total_q <= kept_next;
							overflow_q   <= ovf_next;
						end
					end
				end
				ST_DRAIN: begin
					if (rd_issue) begin
						rd_ptr_q <= rd_ptr_q + CNT_W'(1);
						if (rd_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// The output queue is never written while full.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (obuf_level < OBUF_LVL_W'(OBUF_DEPTH)))
		else $error("output queue written while full");

	// Neither the null count nor the kept count ever exceeds the row limit.
	a_null_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(null_total_q <= MAX_CNT) && (kept_total_q <= MAX_CNT))
		else $error("column counter beyond the row limit");

	// During a drain the read pointer stays inside the queued entries.
	a_drain_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (rd_ptr_q < drain_len_q))
		else $error("drain read beyond queued entries");

	// A read issued last cycle always comes back as a pushed beat.
	a_read_push: assert property (@(posedge clk) disable iff (!arst_n)
		rd_issue |=> push)
		else $error("drain read lost");
`endif

endmodule
